FILE: hdl/pse_pkg.sv
// pse_pkg: shared constants, token and result types, mode, status and state codes
// for the postfix stack evaluator. Depends on nothing.
package pse_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int WORD_W      = 32;
    localparam int MODE_W      = 3;
    localparam int DEPTH_OUT_W = 5;
    localparam int STATUS_W    = 2;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DIV_CNT_W   = $clog2(WORD_W);

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH   = 3'd0,
        MODE_ADD    = 3'd1,
        MODE_SUB    = 3'd2,
        MODE_MUL    = 3'd3,
        MODE_DIV    = 3'd4,
        MODE_FINISH = 3'd5
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_DIVZ  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_READ,
        S_DIV,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic signed [WORD_W-1:0] operand;
    } t_in;

    typedef struct packed {
        logic signed [WORD_W-1:0] top_value;
        logic [DEPTH_OUT_W-1:0]   depth;
        logic [STATUS_W-1:0]      status;
    } t_out;

endpackage

FILE: hdl/pse_stack_ram.sv
// pse_stack_ram: stack entry storage, one write port and one read port with
// registered read data. Depends on pse_pkg.
module pse_stack_ram import pse_pkg::*; (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WORD_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WORD_W-1:0] o_rd_data
);

    logic [WORD_W-1:0] r_mem [STACK_DEPTH];
    logic [WORD_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hdl/pse_divider.sv
// pse_divider: signed division truncating toward zero, restoring, one quotient
// bit per cycle on magnitudes. Depends on pse_pkg.
module pse_divider import pse_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [WORD_W-1:0] i_dividend,
    input  logic [WORD_W-1:0] i_divisor,
    output logic              o_done,
    output logic [WORD_W-1:0] o_quotient
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [WORD_W:0]      r_rem;
    logic [WORD_W-1:0]    r_quo;
    logic [WORD_W-1:0]    r_dvs;
    logic                 r_neg;

    logic [WORD_W:0]      w_shift;
    logic [WORD_W:0]      w_diff;
    logic [WORD_W-1:0]    w_abs_a;
    logic [WORD_W-1:0]    w_abs_b;

    assign w_abs_a = i_dividend[WORD_W-1] ? (WORD_W'(0) - i_dividend) : i_dividend;
    assign w_abs_b = i_divisor[WORD_W-1]  ? (WORD_W'(0) - i_divisor)  : i_divisor;
    assign w_shift = {r_rem[WORD_W-1:0], r_quo[WORD_W-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(WORD_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - DIV_CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= w_abs_a;
            r_dvs <= w_abs_b;
            r_neg <= i_dividend[WORD_W-1] ^ i_divisor[WORD_W-1];
        end else if (r_busy) begin
            if (!w_diff[WORD_W]) begin
                r_rem <= w_diff;
                r_quo <= {r_quo[WORD_W-2:0], 1'b1};
            end else begin
                r_rem <= w_shift;
                r_quo <= {r_quo[WORD_W-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? (WORD_W'(0) - r_quo) : r_quo;

endmodule

FILE: hdl/postfix_stack_evaluator.sv
// Postfix stack evaluator: takes one reverse Polish token per transfer (push an
// operand, add, subtract, multiply, divide, or finish and pop) and gives one result
// transfer per token: the new top (the popped value on finish, zero when the stack
// is empty), the depth and a status (ok, underflow, overflow, divide by zero).
// Errors leave the stack unchanged; arithmetic wraps at 32 bits and division
// truncates toward zero. One token is worked at a time. A push, an error, an
// ignored mode and a finish that empties the stack go from decode straight to
// commit. Add, subtract, multiply, divide and a finish that leaves entries behind
// first read the entry below the top from the stack memory, whose read data is
// registered; divide then waits on the restoring divider, which retires one
// quotient bit per cycle. The next token is taken once the commit of the last one
// is done. A waiting result does not hold off the next token: it is only the
// commit of that token that waits for the output register to free. No clearing
// pass is needed after reset.
// Depends on pse_pkg, pse_stack_ram and pse_divider.
module postfix_stack_evaluator import pse_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    // control state
    t_state            r_state,     n_state;
    logic [CNT_W-1:0]  r_count,     n_count;
    logic              r_out_valid, n_out_valid;
    // payload
    t_in               r_in,        n_in;
    logic [WORD_W-1:0] r_top,       n_top;     // cached copy of the top entry
    logic [WORD_W-1:0] r_lhs,       n_lhs;     // entry below the top, once read
    logic [WORD_W-1:0] r_res,       n_res;
    t_status           r_status,    n_status;
    t_out              r_out,       n_out;

    // memory and divider hookup
    logic              w_wr_en;
    logic [ADDR_W-1:0] w_wr_addr;
    logic [WORD_W-1:0] w_wr_data;
    logic              w_rd_en;
    logic [WORD_W-1:0] w_rd_data;
    logic              w_div_start;
    logic              w_div_done;
    logic [WORD_W-1:0] w_quotient;

    logic [WORD_W-1:0] w_topz;
    logic [ADDR_W-1:0] w_below;
    logic [WORD_W-1:0] w_prod;
    logic              w_commit_ok;

    assign w_topz      = (r_count == '0) ? '0 : r_top;
    assign w_below     = ADDR_W'(r_count - CNT_W'(2));
    assign w_prod      = w_rd_data * r_top;     // low word only, sign-agnostic
    assign w_commit_ok = (r_status == ST_OK);

    pse_stack_ram u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_below),
        .o_rd_data (w_rd_data)
    );

    pse_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_rd_data),
        .i_divisor  (r_top),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in     <= n_in;
        r_top    <= n_top;
        r_lhs    <= n_lhs;
        r_res    <= n_res;
        r_status <= n_status;
        r_out    <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_in        = r_in;
        n_top       = r_top;
        n_lhs       = r_lhs;
        n_res       = r_res;
        n_status    = r_status;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        o_in_ready  = 1'b0;
        w_wr_en     = 1'b0;
        w_wr_addr   = w_below;
        w_wr_data   = r_res;
        w_rd_en     = 1'b0;
        w_div_start = 1'b0;

        // output register drains independently of the token in work
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_in    = i_in;
                    n_state = S_DECODE;
                end
            end

            S_DECODE: begin
                n_state  = S_EMIT;
                n_status = ST_OK;
                case (r_in.mode)
                    MODE_PUSH: begin
                        if (r_count == CNT_W'(STACK_DEPTH)) begin
                            n_status = ST_OVER;
                            n_res    = r_top;
                        end else begin
                            n_res = r_in.operand;
                        end
                    end
                    MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV: begin
                        if (r_count < CNT_W'(2)) begin
                            n_status = ST_UNDER;
                            n_res    = w_topz;
                        end else if (r_in.mode == MODE_DIV && r_top == '0) begin
                            n_status = ST_DIVZ;
                            n_res    = r_top;
                        end else begin
                            w_rd_en = 1'b1;
                            n_state = S_READ;
                        end
                    end
                    MODE_FINISH: begin
                        if (r_count == '0) begin
                            n_status = ST_UNDER;
                            n_res    = '0;
                        end else begin
                            n_res = r_top;
                            // fetch the new top so the cache stays right after the pop
                            if (r_count >= CNT_W'(2)) begin
                                w_rd_en = 1'b1;
                                n_state = S_READ;
                            end
                        end
                    end
                    default: begin
                        n_res = w_topz;     // unused modes leave everything alone
                    end
                endcase
            end

            S_READ: begin
                n_lhs   = w_rd_data;
                n_state = S_EMIT;
                case (r_in.mode)
                    MODE_ADD: n_res = w_rd_data + r_top;
                    MODE_SUB: n_res = w_rd_data - r_top;
                    MODE_MUL: n_res = w_prod;
                    MODE_DIV: begin
                        w_div_start = 1'b1;
                        n_state     = S_DIV;
                    end
                    default: begin
                        // finish: popped value already in r_res
                    end
                endcase
            end

            S_DIV: begin
                if (w_div_done) begin
                    n_res   = w_quotient;
                    n_state = S_EMIT;
                end
            end

            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    if (w_commit_ok) begin
                        case (r_in.mode)
                            MODE_PUSH: begin
                                w_wr_en   = 1'b1;
                                w_wr_addr = ADDR_W'(r_count);
                                w_wr_data = r_in.operand;
                                n_top     = r_in.operand;
                                n_count   = r_count + CNT_W'(1);
                            end
                            MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV: begin
                                w_wr_en = 1'b1;
                                n_top   = r_res;
                                n_count = r_count - CNT_W'(1);
                            end
                            MODE_FINISH: begin
                                n_top   = r_lhs;
                                n_count = r_count - CNT_W'(1);
                            end
                            default: begin
                            end
                        endcase
                    end
                    n_out.top_value = r_res;
                    n_out.depth     = DEPTH_OUT_W'(n_count);
                    n_out.status    = r_status;
                    n_out_valid     = 1'b1;
                    n_state         = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // a new result only ever appears from the commit step
    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_EMIT))
        else $error("result raised outside commit");

    // the depth only moves at commit
    a_count_at_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_count != $past(r_count)) |-> $past(r_state == S_EMIT))
        else $error("stack depth changed outside commit");

    // the divider reports only to a token waiting on it
    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished with no divide pending");

    // depth never passes the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(STACK_DEPTH))
        else $error("stack depth beyond capacity");

endmodule
